// File: design/taa_pkg.sv
`default_nettype none

package taa_pkg;

    // Field widths
    localparam int unsigned RAW_W    = 12;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned TEMP_W   = 16;
    localparam int unsigned FRAC_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Default depth of the sample ring
    localparam int unsigned WINDOW_SIZE_DEF = 5;

    // Sensor range in 1/16 degree
    localparam logic signed [RAW_W-1:0] RAW_MIN = -12'sd880;
    localparam logic signed [RAW_W-1:0] RAW_MAX = 12'sd2000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_FRAC  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_MS = 2'd3;

    // Register reset values
    localparam logic signed [TEMP_W-1:0] HIGH_THR_RST   = 16'sd12800;
    localparam logic signed [TEMP_W-1:0] RESET_THR_RST  = 16'sd10240;
    localparam logic [FRAC_W-1:0]        JUMP_FRAC_RST  = 8'd26;
    localparam logic [TIME_W-1:0]        CONFIRM_MS_RST = 32'd5000;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_reading;
        logic [TIME_W-1:0]       now_ms;
    } t_in_word;

    typedef struct packed {
        logic signed [TEMP_W-1:0] average_temp;
        logic                     alert;
        logic                     jump_detected;
    } t_out_word;

endpackage

`default_nettype wire

// File: design/temperature_average_alert.sv
`default_nettype none

// Windowed mean temperature with a baseline jump alarm and a confirmed
// high-temperature alarm. Each input word carries one raw reading in 1/16
// degree and a millisecond timestamp; each accepted word yields exactly one
// output word with the mean of the last clamped readings, up to WINDOW_SIZE, in
// 1/256 degree (truncated toward zero), the alert flag after this reading,
// and whether this reading fired the jump test. The block handles one word
// at a time: after acceptance it sums the ring one entry per cycle behind
// the registered read of the ring, divides by the fill count with a
// restoring divider that yields one quotient bit per cycle, restores the
// sign in S_MEAN and then makes the baseline, jump and timer decisions in
// S_BASE, S_MUL, S_JUMP and S_TIMER. The divider works on MAG_W =
// 15 + clog2(WINDOW_SIZE + 1) magnitude bits. The input is ready again as
// soon as the result is in the output register, so a result waiting to be
// taken does not hold up the next word unless the following result is
// ready first. The configuration port is always ready; registers should
// only be written while no word is in flight.
module temperature_average_alert #(
    parameter int unsigned WINDOW_SIZE = taa_pkg::WINDOW_SIZE_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input words
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire taa_pkg::t_in_word                  i_in_word,
    // Output words
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output taa_pkg::t_out_word                      o_out_word,
    // Configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [taa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [taa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import taa_pkg::*;

    // Ring index, fill count, sum and divider widths all follow the window.
    localparam int unsigned IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int unsigned SUM_W = RAW_W + CNT_W;
    // Magnitude of sixteen times the sum.
    localparam int unsigned MAG_W = SUM_W + 3;
    localparam int unsigned BIT_W = $clog2(MAG_W);
    localparam int unsigned PROD_W = TEMP_W + FRAC_W + 2;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SUM   = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_MEAN  = 8'b0000_1000,
        S_BASE  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_JUMP  = 8'b0100_0000,
        S_TIMER = 8'b1000_0000
    } t_state;

    // Configuration registers.
    logic signed [TEMP_W-1:0] r_high_thr;
    logic signed [TEMP_W-1:0] r_reset_thr;
    logic [FRAC_W-1:0]        r_jump_frac;
    logic [TIME_W-1:0]        r_confirm_ms;

    // Sample ring; entries are only summed once written.
    logic signed [RAW_W-1:0]  r_window [WINDOW_SIZE];
    logic [IDX_W-1:0]         r_write_index;
    logic [CNT_W-1:0]         r_fill_count;

    // Alarm state.
    logic signed [TEMP_W-1:0] r_baseline;
    logic                     r_baseline_valid;
    logic                     r_alert;
    logic                     r_high_pending;
    logic [TIME_W-1:0]        r_pending_start;

    // Sequencer and working registers.
    t_state                   r_state;
    logic [TIME_W-1:0]        r_now;
    logic [CNT_W-1:0]         r_idx;
    logic signed [RAW_W-1:0]  r_rd;
    logic                     r_rd_vld;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_div;
    logic [CNT_W-1:0]         r_rem;
    logic [BIT_W-1:0]         r_bit;
    logic signed [TEMP_W-1:0] r_mean;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_jump;

    // Output register.
    logic                     r_out_valid;
    t_out_word                r_out_word;

    logic                     in_accept;
    logic                     out_free;
    logic signed [RAW_W-1:0]  n_clamped;
    logic [SUM_W+3:0]         n_sum16;
    logic [MAG_W-1:0]         n_abs;
    logic [CNT_W:0]           n_rem_sh;
    logic                     n_ge;
    logic [MAG_W-1:0]         n_quot;
    logic [PROD_W-FRAC_W-1:0] n_scale;
    logic signed [PROD_W-1:0] n_mean_sh;
    logic                     n_jump;
    logic [TIME_W-1:0]        n_elapsed;
    logic                     n_alert;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;

    // Saturate the reading to the sensor range before it is stored.
    always_comb begin
        if (i_in_word.raw_reading < RAW_MIN) begin
            n_clamped = RAW_MIN;
        end else if (i_in_word.raw_reading > RAW_MAX) begin
            n_clamped = RAW_MAX;
        end else begin
            n_clamped = i_in_word.raw_reading;
        end
    end

    // Divider operand: the magnitude of sixteen times the sum.
    always_comb begin
        n_sum16 = {r_sum, 4'b0000};
        n_abs   = r_sum[SUM_W-1] ? MAG_W'(~n_sum16 + 1'b1) : MAG_W'(n_sum16);
    end

    // One restoring division step.
    always_comb begin
        n_rem_sh = {r_rem, r_div[MAG_W-1]};
        n_ge     = (n_rem_sh >= {1'b0, r_fill_count});
        n_quot   = r_neg ? (~r_div + 1'b1) : r_div;
    end

    // Jump test in exact integer form: mean * 256 against
    // baseline * (256 + fraction).
    always_comb begin
        n_scale   = (PROD_W-FRAC_W)'({1'b0, r_jump_frac}) + (PROD_W-FRAC_W)'(256);
        n_mean_sh = $signed({{(PROD_W-TEMP_W-8){r_mean[TEMP_W-1]}}, r_mean, 8'h00});
        n_jump    = (n_mean_sh > r_prod);
    end

    // Confirmation timer and clear test; the elapsed time wraps with the clock.
    always_comb begin
        n_elapsed = r_now - r_pending_start;
        n_alert   = r_alert;
        if (!r_alert) begin
            if ((r_mean > r_high_thr) && r_high_pending && (n_elapsed > r_confirm_ms)) begin
                n_alert = 1'b1;
            end
        end else if (r_mean < r_reset_thr) begin
            n_alert = 1'b0;
        end
    end

    // Ring storage and its read port.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_window[r_write_index] <= n_clamped;
        end
        r_rd <= r_window[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr       <= HIGH_THR_RST;
            r_reset_thr      <= RESET_THR_RST;
            r_jump_frac      <= JUMP_FRAC_RST;
            r_confirm_ms     <= CONFIRM_MS_RST;
            r_write_index    <= '0;
            r_fill_count     <= '0;
            r_baseline       <= '0;
            r_baseline_valid <= 1'b0;
            r_alert          <= 1'b0;
            r_high_pending   <= 1'b0;
            r_pending_start  <= '0;
            r_state          <= S_IDLE;
            r_rd_vld         <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            // Configuration writes; an index outside the list is ignored.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HIGH_THR: begin
                        r_high_thr <= i_cfg_data[TEMP_W-1:0];
                    end
                    CFG_RESET_THR: begin
                        r_reset_thr <= i_cfg_data[TEMP_W-1:0];
                    end
                    CFG_JUMP_FRAC: begin
                        r_jump_frac <= i_cfg_data[FRAC_W-1:0];
                    end
                    CFG_CONFIRM_MS: begin
                        r_confirm_ms <= i_cfg_data[TIME_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_now <= i_in_word.now_ms;
                        if (r_write_index == IDX_W'(WINDOW_SIZE - 1)) begin
                            r_write_index <= '0;
                        end else begin
                            r_write_index <= r_write_index + 1'b1;
                        end
                        if (r_fill_count != CNT_W'(WINDOW_SIZE)) begin
                            r_fill_count <= r_fill_count + 1'b1;
                        end
                        r_idx    <= '0;
                        r_sum    <= '0;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_SUM;
                    end
                end
                S_SUM: begin
                    // Each read lands in r_rd and is accumulated in the cycle after.
                    if (r_rd_vld) begin
                        r_sum <= r_sum + SUM_W'(r_rd);
                    end
                    if (r_idx != r_fill_count) begin
                        r_idx    <= r_idx + 1'b1;
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_neg   <= r_sum[SUM_W-1];
                            r_div   <= n_abs;
                            r_rem   <= '0;
                            r_bit   <= BIT_W'(MAG_W - 1);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_div <= {r_div[MAG_W-2:0], n_ge};
                    if (n_ge) begin
                        r_rem <= CNT_W'(n_rem_sh - {1'b0, r_fill_count});
                    end else begin
                        r_rem <= n_rem_sh[CNT_W-1:0];
                    end
                    if (r_bit == '0) begin
                        r_state <= S_MEAN;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_MEAN: begin
                    // Quotient of magnitudes, sign restored: truncation toward zero.
                    r_mean  <= n_quot[TEMP_W-1:0];
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    // First mean sets the baseline; later it follows the mean down.
                    if (!r_baseline_valid || (r_mean < r_baseline)) begin
                        r_baseline <= r_mean;
                    end
                    r_baseline_valid <= 1'b1;
                    r_state          <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_baseline) * PROD_W'($signed({1'b0, n_scale}));
                    r_state <= S_JUMP;
                end
                S_JUMP: begin
                    r_jump <= n_jump;
                    if (n_jump) begin
                        r_alert    <= 1'b1;
                        r_baseline <= r_mean;
                    end
                    r_state <= S_TIMER;
                end
                S_TIMER: begin
                    if (out_free) begin
                        if (!r_alert) begin
                            if (r_mean > r_high_thr) begin
                                if (!r_high_pending) begin
                                    r_high_pending  <= 1'b1;
                                    r_pending_start <= r_now;
                                end
                            end else begin
                                r_high_pending <= 1'b0;
                            end
                        end
                        r_alert                  <= n_alert;
                        r_out_word.average_temp  <= r_mean;
                        r_out_word.alert         <= n_alert;
                        r_out_word.jump_detected <= r_jump;
                        r_out_valid              <= 1'b1;
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The block is busy for the whole of an item once it is accepted.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("input ready straight after an accepted word");

    // Ring pointers stay inside the window.
    a_ring_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill_count <= CNT_W'(WINDOW_SIZE)) && (r_write_index < IDX_W'(WINDOW_SIZE)))
        else $error("ring pointer outside the window");

    // A finished item with a free output register always lands there.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TIMER && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded into the output register");

    // A fired jump test moves the baseline to the mean and raises the alert.
    a_jump_moves_baseline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_JUMP && n_jump) |=> (r_baseline == $past(r_mean) && r_alert))
        else $error("jump test did not update baseline and alert");

    // A division always starts after the ring holds at least one sample.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_fill_count != '0))
        else $error("division by an empty fill count");

endmodule

`default_nettype wire
